// ===== rtl/core/msw_pkg.sv =====
package msw_pkg;

    // Field widths
    localparam int ADC_W  = 12;
    localparam int VOLT_W = 16;
    localparam int SPD_W  = 15;
    localparam int RPM_W  = 25;
    localparam int RATE_W = 14;
    localparam int PPR_W  = 11;
    localparam int PROD_W = SPD_W + RATE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 1'd1;

    localparam logic [RATE_W-1:0] RATE_RESET = 14'd100;
    localparam logic [PPR_W-1:0]  PPR_RESET  = 11'd1;

    // Input opcodes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Saturation limit for pulse count and frequency
    localparam logic [SPD_W-1:0] COUNT_MAX = 15'd32767;
    // rpm in Q4: 60 s/min times 16
    localparam logic [RPM_W-1:0] RPM_Q4_SCALE = 25'd960;

    // One window slot: all three channels side by side
    typedef struct packed {
        logic [VOLT_W-1:0] mot;
        logic [VOLT_W-1:0] gen;
        logic [SPD_W-1:0]  spd;
    } t_window_entry;

endpackage

// ===== rtl/core/msw_if.sv =====
// Sample/edge input channel
interface msw_in_if import msw_pkg::*;;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADC_W-1:0]  mot_adc_mv;
    logic [ADC_W-1:0]  gen_adc_mv;
    logic [VOLT_W-1:0] mot_volt_mv;
    logic [VOLT_W-1:0] gen_volt_mv;

    modport source (
        output valid, opcode, mot_adc_mv, gen_adc_mv, mot_volt_mv, gen_volt_mv,
        input  ready
    );
    modport sink (
        input  valid, opcode, mot_adc_mv, gen_adc_mv, mot_volt_mv, gen_volt_mv,
        output ready
    );
endinterface

// Averaged result channel
interface msw_out_if import msw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] mot_avg_mv;
    logic [VOLT_W-1:0] gen_avg_mv;
    logic [ADC_W-1:0]  mot_raw_mv;
    logic [ADC_W-1:0]  gen_raw_mv;
    logic [SPD_W-1:0]  speed_avg_hz;
    logic [RPM_W-1:0]  rpm_q4;

    modport source (
        output valid, mot_avg_mv, gen_avg_mv, mot_raw_mv, gen_raw_mv, speed_avg_hz, rpm_q4,
        input  ready
    );
    modport sink (
        input  valid, mot_avg_mv, gen_avg_mv, mot_raw_mv, gen_raw_mv, speed_avg_hz, rpm_q4,
        output ready
    );
endinterface

// ===== rtl/core/msw_ram.sv =====
module msw_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/msw_div.sv =====
module msw_div #(
    parameter int DW = 25,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_dvs;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_q;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        q_bit;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = (trial >= {1'b0, r_dvs});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[VW-1:0] : trial[VW-1:0];
            r_q   <= {r_q[DW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/motor_sample_window_averager.sv =====
// An edge transfer updates the pulse counter in its accept cycle and gives no result.
// A tick gives its result after two passes through the bit-serial dividers:
// averages, then rpm; no new item is taken until that result is registered.
// Edges are taken one per cycle while idle.
// Reset: synchronous, active low; clears counter, sums, slot, fill count and config.
// Window RAM needs no clearing pass: slots beyond the fill count read as zero.
module motor_sample_window_averager import msw_pkg::*; #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    msw_in_if.sink                i_sample,
    msw_out_if.source             o_result
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = VOLT_W + CNT_W;
    localparam int DIV_W  = (SUM_W > RPM_W) ? SUM_W : RPM_W;
    localparam int DVS_W  = (CNT_W > PPR_W) ? CNT_W : PPR_W;
    localparam int ENT_W  = $bits(t_window_entry);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_AVG   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_RPMS  = 3'd5;
    localparam logic [2:0] S_RPM   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]        r_state;
    logic [RATE_W-1:0] r_rate;
    logic [PPR_W-1:0]  r_ppr;
    logic [SPD_W-1:0]  r_pulse;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_mot_sum;
    logic [SUM_W-1:0]  r_gen_sum;
    logic [SUM_W-1:0]  r_spd_sum;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_fill;
    logic [VOLT_W-1:0] r_mot_v;
    logic [VOLT_W-1:0] r_gen_v;
    logic [ADC_W-1:0]  r_mot_adc;
    logic [ADC_W-1:0]  r_gen_adc;
    logic [VOLT_W-1:0] r_mot_avg;
    logic [VOLT_W-1:0] r_gen_avg;
    logic [SPD_W-1:0]  r_spd_avg;
    logic [RPM_W-1:0]  r_rpm_num;

    logic              r_out_valid;
    logic [VOLT_W-1:0] r_out_mot_avg;
    logic [VOLT_W-1:0] r_out_gen_avg;
    logic [ADC_W-1:0]  r_out_mot_raw;
    logic [ADC_W-1:0]  r_out_gen_raw;
    logic [SPD_W-1:0]  r_out_spd_avg;
    logic [RPM_W-1:0]  r_out_rpm;

    logic              in_xfer;
    logic              out_free;
    logic              win_full;
    logic [SPD_W-1:0]  speed_hz;
    logic [PPR_W-1:0]  ppr_eff;
    logic [SLOT_W-1:0] n_slot;
    t_window_entry     ram_rdata;
    t_window_entry     old_entry;
    t_window_entry     new_entry;
    logic [ENT_W-1:0]  ram_rword;

    logic              avg_start;
    logic              rpm_start;
    logic              spd_start;
    logic [DIV_W-1:0]  spd_dividend;
    logic [DVS_W-1:0]  spd_divisor;
    logic              mot_done;
    logic              gen_done;
    logic              spd_done;
    logic [DIV_W-1:0]  mot_quot;
    logic [DIV_W-1:0]  gen_quot;
    logic [DIV_W-1:0]  spd_quot;

    assign in_xfer  = i_sample.valid && i_sample.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign win_full = (r_fill == CNT_W'(WINDOW_LEN));

    // Saturated frequency from the registered product
    assign speed_hz = (r_prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : r_prod[SPD_W-1:0];
    assign ppr_eff  = (r_ppr == '0) ? PPR_W'(1) : r_ppr;
    assign n_slot   = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;

    // Slots not yet written since reset read as zero
    assign ram_rdata = t_window_entry'(ram_rword);
    assign old_entry = win_full ? ram_rdata : '0;
    always_comb begin
        new_entry.mot = r_mot_v;
        new_entry.gen = r_gen_v;
        new_entry.spd = speed_hz;
    end

    // Window storage
    msw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_slot),
        .i_wdata (ENT_W'(new_entry)),
        .i_raddr (r_slot),
        .o_rdata (ram_rword)
    );

    // Dividers: three averages in parallel, speed unit reused for rpm
    assign avg_start    = (r_state == S_START);
    assign rpm_start    = (r_state == S_RPMS);
    assign spd_start    = avg_start || rpm_start;
    assign spd_dividend = rpm_start ? DIV_W'(r_rpm_num) : DIV_W'(r_spd_sum);
    assign spd_divisor  = rpm_start ? DVS_W'(ppr_eff) : DVS_W'(r_fill);

    msw_div #(.DW(DIV_W), .VW(DVS_W)) u_div_mot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (avg_start),
        .i_dividend (DIV_W'(r_mot_sum)),
        .i_divisor  (DVS_W'(r_fill)),
        .o_done     (mot_done),
        .o_quot     (mot_quot)
    );

    msw_div #(.DW(DIV_W), .VW(DVS_W)) u_div_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (avg_start),
        .i_dividend (DIV_W'(r_gen_sum)),
        .i_divisor  (DVS_W'(r_fill)),
        .o_done     (gen_done),
        .o_quot     (gen_quot)
    );

    msw_div #(.DW(DIV_W), .VW(DVS_W)) u_div_spd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (spd_start),
        .i_dividend (spd_dividend),
        .i_divisor  (spd_divisor),
        .o_done     (spd_done),
        .o_quot     (spd_quot)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_ppr  <= PPR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_RATE:    r_rate <= i_cfg_wdata[RATE_W-1:0];
                CFG_PULSES_PER_REV: r_ppr  <= i_cfg_wdata[PPR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pulse   <= '0;
            r_mot_sum <= '0;
            r_gen_sum <= '0;
            r_spd_sum <= '0;
            r_slot    <= '0;
            r_fill    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_sample.opcode == OP_TICK) begin
                            r_pulse <= '0;
                            r_state <= S_READ;
                        end else if (r_pulse != COUNT_MAX) begin
                            r_pulse <= r_pulse + 1'b1;
                        end
                    end
                end
                S_READ: begin
                    // Read-modify-write of the current slot
                    r_mot_sum <= r_mot_sum - SUM_W'(old_entry.mot) + SUM_W'(r_mot_v);
                    r_gen_sum <= r_gen_sum - SUM_W'(old_entry.gen) + SUM_W'(r_gen_v);
                    r_spd_sum <= r_spd_sum - SUM_W'(old_entry.spd) + SUM_W'(speed_hz);
                    if (!win_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_slot  <= n_slot;
                    r_state <= S_START;
                end
                S_START: r_state <= S_AVG;
                S_AVG: begin
                    if (mot_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_RPMS;
                S_RPMS: r_state <= S_RPM;
                S_RPM: begin
                    if (spd_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Tick capture, product and average registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer) begin
            r_prod    <= PROD_W'(r_pulse) * PROD_W'(r_rate);
            r_mot_v   <= i_sample.mot_volt_mv;
            r_gen_v   <= i_sample.gen_volt_mv;
            r_mot_adc <= i_sample.mot_adc_mv;
            r_gen_adc <= i_sample.gen_adc_mv;
        end
        if (r_state == S_MUL) begin
            r_mot_avg <= mot_quot[VOLT_W-1:0];
            r_gen_avg <= gen_quot[VOLT_W-1:0];
            r_spd_avg <= spd_quot[SPD_W-1:0];
            r_rpm_num <= RPM_W'(spd_quot[SPD_W-1:0]) * RPM_Q4_SCALE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_mot_avg <= r_mot_avg;
            r_out_gen_avg <= r_gen_avg;
            r_out_mot_raw <= r_mot_adc;
            r_out_gen_raw <= r_gen_adc;
            r_out_spd_avg <= r_spd_avg;
            r_out_rpm     <= spd_quot[RPM_W-1:0];
        end
    end

    // Note: gen_done mirrors mot_done; both dividers start together
    assign i_sample.ready        = (r_state == S_IDLE) && !(gen_done && !mot_done);
    assign o_result.valid        = r_out_valid;
    assign o_result.mot_avg_mv   = r_out_mot_avg;
    assign o_result.gen_avg_mv   = r_out_gen_avg;
    assign o_result.mot_raw_mv   = r_out_mot_raw;
    assign o_result.gen_raw_mv   = r_out_gen_raw;
    assign o_result.speed_avg_hz = r_out_spd_avg;
    assign o_result.rpm_q4       = r_out_rpm;

endmodule

// ===== rtl/core/msw_chk.sv =====
module msw_chk import msw_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_opcode,
    input logic             out_valid,
    input logic             out_ready,
    input logic [VOLT_W-1:0] out_mot_avg,
    input logic [RPM_W-1:0] out_rpm
);

    // Result stays offered with a fixed payload until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mot_avg) && $stable(out_rpm))
        else $error("result dropped or changed while stalled");

    // Reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    // An accepted tick makes the block busy in the next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_opcode == OP_TICK) |=> !in_ready)
        else $error("input still ready right after a tick");

    // An edge transfer never raises a result
    a_edge_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_opcode == OP_EDGE) && !out_valid |=> !out_valid)
        else $error("edge transfer produced a result");

    // rpm never exceeds the top frequency scaled by 960
    a_rpm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_rpm <= 25'd31456320)
        else $error("rpm out of range");

endmodule

bind motor_sample_window_averager msw_chk u_msw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_sample.valid),
    .in_ready    (i_sample.ready),
    .in_opcode   (i_sample.opcode),
    .out_valid   (o_result.valid),
    .out_ready   (o_result.ready),
    .out_mot_avg (o_result.mot_avg_mv),
    .out_rpm     (o_result.rpm_q4)
);

// ===== tb/testbench.sv =====
module testbench;
    import msw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WIN           = 16;
    localparam int          SLOT_BITS     = $clog2(WIN);
    localparam int          SETTLE_CYCLES = 80;
    localparam int          LONG_HOLD     = 600;
    localparam int          RANDOM_ITEMS  = 1060;
    localparam int          PHASES        = 8;
    localparam int          MAX_PRINTED   = 100;
    localparam int          DIR_ROWS      = 22;

    typedef struct packed {
        logic              op;
        logic [ADC_W-1:0]  mot_adc;
        logic [ADC_W-1:0]  gen_adc;
        logic [VOLT_W-1:0] mot_volt;
        logic [VOLT_W-1:0] gen_volt;
    } t_sample;

    typedef struct packed {
        logic [VOLT_W-1:0] mot_avg;
        logic [VOLT_W-1:0] gen_avg;
        logic [ADC_W-1:0]  mot_raw;
        logic [ADC_W-1:0]  gen_raw;
        logic [SPD_W-1:0]  spd_avg;
        logic [RPM_W-1:0]  rpm;
    } t_avg_result;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_sample               item;
        logic [15:0]           reps;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  typed;
        t_avg_result           want;
    } t_stim_row;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    msw_in_if  sample_if ();
    msw_out_if result_if ();

    motor_sample_window_averager #(
        .WINDOW_LEN (WIN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (sample_if.sink),
        .o_result    (result_if.source)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: tach counter, three boxcar windows, running sums, registers
    logic [RATE_W-1:0]    cfg_rate;
    logic [PPR_W-1:0]     cfg_ppr;
    logic [SPD_W-1:0]     tach_count;
    logic [VOLT_W-1:0]    mot_hist [WIN];
    logic [VOLT_W-1:0]    gen_hist [WIN];
    logic [SPD_W-1:0]     spd_hist [WIN];
    logic [31:0]          mot_total;
    logic [31:0]          gen_total;
    logic [31:0]          spd_total;
    logic [SLOT_BITS-1:0] slot_ptr;
    int unsigned          fill_level;

    t_avg_result       pending_averages [$];

    int unsigned       mismatches      = 0;
    int unsigned       results_checked = 0;
    int unsigned       edges_sent      = 0;
    int unsigned       ticks_sent      = 0;
    int unsigned       reg_writes      = 0;
    int unsigned       burst_left      = 0;
    int unsigned       holds_asked     = 0;
    int unsigned       holds_granted   = 0;

    // Directed stimulus: reset values, extremes, saturation, odd register settings
    t_stim_row directed_tab [DIR_ROWS] = '{
        // first tick after reset: empty windows, idle counter
        '{ROW_ITEM, '{OP_TICK, 12'd0, 12'd0, 16'd0, 16'd0}, 16'd1, CFG_SAMPLE_RATE, 14'd0,
          1'b1, '{16'd0, 16'd0, 12'd0, 12'd0, 15'd0, 25'd0}},
        '{ROW_ITEM, '{OP_EDGE, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        // full scale tick, one pulse at the reset rate of 100
        '{ROW_ITEM, '{OP_TICK, 12'd4095, 12'd4095, 16'd65535, 16'd65535}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0,
          1'b1, '{16'd32767, 16'd32767, 12'd4095, 12'd4095, 15'd50, 25'd48000}},
        // frequency overflow
        '{ROW_ITEM, '{OP_EDGE, 12'h555, 12'hAAA, 16'h5555, 16'hAAAA}, 16'd330,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_TICK, 12'd1234, 12'd2345, 16'd40000, 16'd9999}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        // lowest nonzero rate: frequency equals the pulse count
        '{ROW_REG, '0, 16'd0, CFG_SAMPLE_RATE, 14'd1, 1'b0, '0},
        '{ROW_ITEM, '{OP_EDGE, 12'hAAA, 12'h555, 16'hAAAA, 16'h5555}, 16'd40,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_TICK, 12'd4095, 12'd0, 16'd0, 16'd65535}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        // zero rate gives zero frequency
        '{ROW_REG, '0, 16'd0, CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_EDGE, 12'd0, 12'd0, 16'd0, 16'd0}, 16'd5,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_TICK, 12'd0, 12'd4095, 16'd65535, 16'd0}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        // zero pulses per rev acts as one
        '{ROW_REG, '0, 16'd0, CFG_PULSES_PER_REV, 14'd0, 1'b0, '0},
        '{ROW_REG, '0, 16'd0, CFG_SAMPLE_RATE, 14'd10000, 1'b0, '0},
        '{ROW_ITEM, '{OP_EDGE, 12'd7, 12'd9, 16'd11, 16'd13}, 16'd3,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_TICK, 12'd2048, 12'd1, 16'd32768, 16'd1}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        // pulses per rev beyond the nominal range, used as written
        '{ROW_REG, '0, 16'd0, CFG_PULSES_PER_REV, 14'd2047, 1'b0, '0},
        '{ROW_ITEM, '{OP_EDGE, 12'd0, 12'd0, 16'd0, 16'd0}, 16'd2,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_TICK, 12'd1, 12'd2048, 16'd1, 16'd32768}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        // both registers at the top of their nominal range
        '{ROW_REG, '0, 16'd0, CFG_SAMPLE_RATE, 14'd16383, 1'b0, '0},
        '{ROW_REG, '0, 16'd0, CFG_PULSES_PER_REV, 14'd1024, 1'b0, '0},
        '{ROW_ITEM, '{OP_EDGE, 12'd0, 12'd0, 16'd0, 16'd0}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0},
        '{ROW_ITEM, '{OP_TICK, 12'd4095, 12'd4095, 16'd65535, 16'd65535}, 16'd1,
          CFG_SAMPLE_RATE, 14'd0, 1'b0, '0}
    };

    // Expected result of one transfer; returns 1 when the transfer is a tick
    function automatic bit compute_window_averages(input t_sample s, output t_avg_result r);
        logic [31:0] hz;
        logic [31:0] mot_a;
        logic [31:0] gen_a;
        logic [31:0] spd_a;
        logic [31:0] divisor;
        logic [31:0] rpm;
        r = '0;
        if (s.op == OP_EDGE) begin
            if (tach_count != COUNT_MAX) tach_count = tach_count + 1'b1;
            return 1'b0;
        end
        hz = 32'(tach_count) * 32'(cfg_rate);
        tach_count = '0;
        if (hz > 32'(COUNT_MAX)) hz = 32'(COUNT_MAX);

        // evict the oldest slot, insert this tick
        mot_total = mot_total - 32'(mot_hist[slot_ptr]) + 32'(s.mot_volt);
        gen_total = gen_total - 32'(gen_hist[slot_ptr]) + 32'(s.gen_volt);
        spd_total = spd_total - 32'(spd_hist[slot_ptr]) + hz;
        mot_hist[slot_ptr] = s.mot_volt;
        gen_hist[slot_ptr] = s.gen_volt;
        spd_hist[slot_ptr] = hz[SPD_W-1:0];
        if (fill_level < WIN) fill_level++;
        slot_ptr = (slot_ptr == SLOT_BITS'(WIN - 1)) ? '0 : slot_ptr + 1'b1;

        mot_a   = mot_total / fill_level;
        gen_a   = gen_total / fill_level;
        spd_a   = spd_total / fill_level;
        divisor = (cfg_ppr == '0) ? 32'd1 : 32'(cfg_ppr);
        rpm     = spd_a * 32'(RPM_Q4_SCALE) / divisor;

        r.mot_avg = mot_a[VOLT_W-1:0];
        r.gen_avg = gen_a[VOLT_W-1:0];
        r.mot_raw = s.mot_adc;
        r.gen_raw = s.gen_adc;
        r.spd_avg = spd_a[SPD_W-1:0];
        r.rpm     = rpm[RPM_W-1:0];
        return 1'b1;
    endfunction

    // Field value biased toward both ends of its range
    function automatic logic [15:0] pick_value(input int unsigned bits);
        logic [15:0] mask;
        mask = 16'((32'd1 << bits) - 1);
        case ($urandom_range(7))
            0:       return '0;
            1:       return mask;
            default: return 16'($urandom) & mask;
        endcase
    endfunction

    function automatic t_sample make_sample(input logic op);
        t_sample     s;
        logic [15:0] v;
        s.op       = op;
        v          = pick_value(ADC_W);
        s.mot_adc  = v[ADC_W-1:0];
        v          = pick_value(ADC_W);
        s.gen_adc  = v[ADC_W-1:0];
        s.mot_volt = pick_value(VOLT_W);
        s.gen_volt = pick_value(VOLT_W);
        return s;
    endfunction

    // Number of edges ahead of a tick; sometimes enough to saturate the frequency
    function automatic int unsigned edge_run_length();
        int unsigned need;
        case ($urandom_range(9))
            0: begin
                need = (cfg_rate == '0) ? 8 : 32'(COUNT_MAX) / 32'(cfg_rate) + 1;
                return (need > 400) ? $urandom_range(40, 13) : need + $urandom_range(3);
            end
            1, 2:    return $urandom_range(40, 9);
            default: return $urandom_range(8);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                      results_checked, field, got, want));
    endtask

    // Offer one item in the sender's burst pattern and record what it should produce
    task automatic offer(input t_sample s, input bit typed, input t_avg_result want);
        t_avg_result predicted;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                sample_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(32, 1);
        end
        burst_left--;
        sample_if.valid       <= 1'b1;
        sample_if.opcode      <= s.op;
        sample_if.mot_adc_mv  <= s.mot_adc;
        sample_if.gen_adc_mv  <= s.gen_adc;
        sample_if.mot_volt_mv <= s.mot_volt;
        sample_if.gen_volt_mv <= s.gen_volt;
        do @(posedge i_clk); while (sample_if.ready !== 1'b1);
        if (compute_window_averages(s, predicted)) begin
            pending_averages.push_back(typed ? want : predicted);
            ticks_sent++;
        end else begin
            edges_sent++;
        end
    endtask

    // Stop offering, let every outstanding tick come out, then let the block settle
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SAMPLE_RATE) cfg_rate = val[RATE_W-1:0];
        else                        cfg_ppr  = val[PPR_W-1:0];
        reg_writes++;
    endtask

    // Receiver: free, random and periodic stall stretches, plus requested long hold-offs
    initial begin : receiver
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned beat;
        int unsigned hold_left;
        mode      = RX_FREE;
        mode_left = 0;
        beat      = 0;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1) begin
                result_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (holds_granted != holds_asked) begin
                holds_granted++;
                hold_left = LONG_HOLD - 1;
                result_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(2));
                    mode_left = $urandom_range(300, 40);
                end
                mode_left--;
                beat++;
                case (mode)
                    RX_FREE:   result_if.ready <= 1'b1;
                    RX_RANDOM: result_if.ready <= ($urandom_range(3) != 0);
                    default:   result_if.ready <= ((beat % 7) > 2);
                endcase
            end
        end
    end

    // Result checker: each transfer against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_avg_result want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_averages.size() == 0) begin
                report_mismatch("result transfer with no tick outstanding");
            end else begin
                want = pending_averages.pop_front();
                check_field("mot_avg_mv",   32'(result_if.mot_avg_mv),   32'(want.mot_avg));
                check_field("gen_avg_mv",   32'(result_if.gen_avg_mv),   32'(want.gen_avg));
                check_field("mot_raw_mv",   32'(result_if.mot_raw_mv),   32'(want.mot_raw));
                check_field("gen_raw_mv",   32'(result_if.gen_raw_mv),   32'(want.gen_raw));
                check_field("speed_avg_hz", 32'(result_if.speed_avg_hz), 32'(want.spd_avg));
                check_field("rpm_q4",       32'(result_if.rpm_q4),       32'(want.rpm));
            end
            results_checked++;
        end
    end

    // Main stimulus
    initial begin : stimulus
        t_sample           s;
        logic [RATE_W-1:0] rate;
        logic [PPR_W-1:0]  ppr;
        int unsigned       rand_items;
        int unsigned       phase_end;
        int unsigned       seq_no;
        int unsigned       run;

        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_SAMPLE_RATE;
        i_cfg_wdata            <= '0;
        sample_if.valid        <= 1'b0;
        sample_if.opcode       <= OP_EDGE;
        sample_if.mot_adc_mv   <= '0;
        sample_if.gen_adc_mv   <= '0;
        sample_if.mot_volt_mv  <= '0;
        sample_if.gen_volt_mv  <= '0;

        cfg_rate   = RATE_RESET;
        cfg_ppr    = PPR_RESET;
        tach_count = '0;
        foreach (mot_hist[i]) begin
            mot_hist[i] = '0;
            gen_hist[i] = '0;
            spd_hist[i] = '0;
        end
        mot_total  = '0;
        gen_total  = '0;
        spd_total  = '0;
        slot_ptr   = '0;
        fill_level = 0;
        rand_items = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_tab[r]) begin
            if (directed_tab[r].kind == ROW_REG) begin
                write_reg(directed_tab[r].reg_idx, directed_tab[r].reg_val);
            end else begin
                repeat (directed_tab[r].reps)
                    offer(directed_tab[r].item, directed_tab[r].typed, directed_tab[r].want);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin rate = 14'd100;   ppr = 11'd4;    end
                1: begin rate = 14'd1;     ppr = 11'd1;    end
                2: begin rate = 14'd10000; ppr = 11'd1024; end
                3: begin rate = 14'd16383; ppr = 11'd2047; end
                4: begin rate = 14'd0;     ppr = 11'd0;    end
                default: begin
                    rate = 14'($urandom_range(10000, 1));
                    ppr  = 11'($urandom_range(1024, 1));
                end
            endcase
            write_reg(CFG_SAMPLE_RATE, rate);
            write_reg(CFG_PULSES_PER_REV, 14'(ppr));
            phase_end = RANDOM_ITEMS * (ph + 1) / PHASES;
            seq_no    = 0;
            while (rand_items < phase_end) begin
                seq_no++;
                // receiver backs off while the sender keeps going
                if (ph == 1 && seq_no == 2) holds_asked++;
                if ($urandom_range(99) < 15) begin
                    // loose item of either kind
                    s = make_sample(logic'($urandom_range(1)));
                    offer(s, 1'b0, '0);
                    rand_items++;
                end else begin
                    // edge run closed by a tick
                    run = edge_run_length();
                    repeat (run) begin
                        s = make_sample(OP_EDGE);
                        offer(s, 1'b0, '0);
                        rand_items++;
                    end
                    s = make_sample(OP_TICK);
                    offer(s, 1'b0, '0);
                    rand_items++;
                end
            end
        end

        drain_results();
        $display("covered %0d edge and %0d tick transfers over %0d register writes",
                 edges_sent, ticks_sent, reg_writes);
        $display("%0d results checked, %0d long output hold-offs, %0d mismatches",
                 results_checked, holds_granted, mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("timeout: %0d ticks still outstanding", pending_averages.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule
